### hdl/box_blur_screen_glow_assert.svh
// ---------------------------------------------------------------------------
// box_blur_screen_glow assertion macros
// Shared property forms for the glow block checks.
// ---------------------------------------------------------------------------
`ifndef BOX_BLUR_SCREEN_GLOW_ASSERT_SVH
`define BOX_BLUR_SCREEN_GLOW_ASSERT_SVH

// same-cycle implication
`define BBSG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// delayed implication
`define BBSG_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) else $error(msg);

`endif

### hdl/bbsg_pkg.sv
// ---------------------------------------------------------------------------
// bbsg_pkg
// Types, constants and codes of the box blur screen glow block.
// ---------------------------------------------------------------------------
package bbsg_pkg;

  localparam int MAX_WIDTH     = 128;
  localparam int MAX_HEIGHT    = 128;
  localparam int MAX_RADIUS    = 30;
  localparam int DEPTH         = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W        = $clog2(DEPTH);
  localparam int SIZE_W        = ADDR_W + 1;
  localparam int COORD_W       = 7;
  localparam int DIM_W         = 8;
  localparam int RAD_W         = 5;
  localparam int STR_W         = 9;
  localparam int CFG_W         = 9;
  localparam int SUM_W         = 14;
  localparam int CNT_W         = 7;
  localparam int DIV_NUM_W     = 24;
  localparam int DIV_DEN_W     = 16;
  localparam int FULL_STRENGTH = 256;
  localparam int BLEND_DIV     = 65280;
  localparam int SCREEN_TOP    = 65025;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_RUN  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;
  localparam logic [1:0] REG_STRENGTH = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       last_pixel;
  } out_item_t;

  typedef struct packed {
    logic run_mode;
    logic load_wr;
    logic rd_accept;
    logic out_load;
    logic run_init;
    logic run_done;
    logic pix_start;
    logic win_step;
    logic div_go;
    logic take_blur;
    logic take_glow;
    logic chan_next;
    logic blend1;
    logic blend2;
    logic row_wr;
    logic glow_wr;
    logic copy_wr;
    logic pix_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic r_zero;
    logic pass_v;
    logic win_last;
    logic div_done;
    logic div_busy;
    logic chan_last;
    logic last_x;
    logic last_y;
    logic out_valid;
  } ctrl_stat_t;

endpackage

### hdl/box_blur_screen_glow.sv
// ---------------------------------------------------------------------------
// box_blur_screen_glow
// Frame glow filter: separable box blur, screen blend, strength mix.
// ---------------------------------------------------------------------------
// A load is taken while idle and does not stall the input. A read holds
// the input for state S_RD, in which its fetched pixel is loaded into the
// result register; a further read is held while a result waits on the
// output, so a read is not taken until the previous result has left. A run
// command walks the frame through three frame memories: each pixel of the
// horizontal and vertical passes costs one memory read per tap of its
// window and one divide per channel on the shared serial divider, three
// per pixel; the blend divide is a combinational shift-and-add step.
// Radius zero copies the source through states S_CRD and S_CWR for each
// pixel. No items are taken during a run.
module box_blur_screen_glow (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [bbsg_pkg::CFG_W-1:0] cfg_data,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  bbsg_pkg::in_item_t         item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output bbsg_pkg::out_item_t        result
);

  `include "box_blur_screen_glow_assert.svh"

  bbsg_pkg::ctrl_cmd_t  cmd;
  bbsg_pkg::ctrl_stat_t stat;

  bbsg_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_cmd   (item.cmd),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  bbsg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

  `BBSG_ASSERT_DLY2(a_read_result, item_valid && !item_stall && (item.cmd == bbsg_pkg::CMD_READ), result_valid, "read transfer gave no result")
  `BBSG_ASSERT_IMP(a_div_idle, cmd.div_go, !stat.div_busy, "divider restarted while busy")
  `BBSG_ASSERT_IMP(a_run_blocks, cmd.run_mode, item_stall, "item transfer during a run")

endmodule

### hdl/bbsg_div.sv
// ---------------------------------------------------------------------------
// bbsg_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module bbsg_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [bbsg_pkg::DIV_NUM_W-1:0] num,
  input  logic [bbsg_pkg::DIV_DEN_W-1:0] den,
  output logic [bbsg_pkg::DIV_NUM_W-1:0] quot,
  output logic                           busy,
  output logic                           done
);

  localparam int NW = bbsg_pkg::DIV_NUM_W;
  localparam int DW = bbsg_pkg::DIV_DEN_W;
  localparam int CW = $clog2(NW);

  logic [NW-1:0] num_sh;
  logic [DW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem, num_sh[NW-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NW-2:0], 1'b0};
      rem    <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quot   <= {quot[NW-2:0], fits};
    end
  end

endmodule

### hdl/bbsg_dp.sv
// ---------------------------------------------------------------------------
// bbsg_dp
// Datapath: frame memories, window sums, blend arithmetic, result register.
// ---------------------------------------------------------------------------
module bbsg_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bbsg_pkg::CFG_W-1:0]   cfg_data,
  input  bbsg_pkg::in_item_t           item,
  input  bbsg_pkg::ctrl_cmd_t          cmd,
  output bbsg_pkg::ctrl_stat_t         stat,
  input  logic                         result_stall,
  output logic                         result_valid,
  output bbsg_pkg::out_item_t          result
);

  localparam int AW = bbsg_pkg::ADDR_W;
  localparam int SW = bbsg_pkg::SIZE_W;
  localparam int XW = bbsg_pkg::COORD_W;
  localparam int DW = bbsg_pkg::DIM_W;

  logic [31:0] src_mem  [bbsg_pkg::DEPTH];
  logic [23:0] row_mem  [bbsg_pkg::DEPTH];
  logic [23:0] glow_mem [bbsg_pkg::DEPTH];

  logic [DW-1:0] fw, fh;
  logic [bbsg_pkg::RAD_W-1:0] rad;
  logic [bbsg_pkg::STR_W-1:0] str;
  logic [DW-1:0] w, h;
  logic [bbsg_pkg::RAD_W-1:0] r;
  logic [bbsg_pkg::STR_W-1:0] k;
  logic [SW-1:0] size;

  logic [SW-1:0] load_pos;
  logic [AW-1:0] read_pos, rd_idx;
  logic          rd_last, idx_last;

  logic          pass_v;
  logic [XW-1:0] x, y, win_n, win_hi;
  logic [AW-1:0] pos, row_base, win_addr;
  logic [bbsg_pkg::CNT_W-1:0] win_cnt;
  logic [bbsg_pkg::SUM_W-1:0] sum [3];
  logic          acc_d;
  logic [1:0]    c;
  logic [7:0]    b [3];
  logic [7:0]    g [3];
  logic [16:0]   m1;
  logic [15:0]   m2;
  logic [24:0]   keep, m3;
  logic [24:0]   blend_sum;
  logic [15:0]   blend_t, blend_q;
  logic [7:0]    glow_q;

  logic [31:0] src_rd;
  logic [23:0] row_rd, glow_rd;
  logic [AW-1:0] src_ra;
  logic [31:0] acc_src;

  logic [XW-1:0] coord;
  logic [8:0]    lo9, hi9, dim9;
  logic [XW-1:0] lo, hi;
  logic [14:0]   lo_w;

  logic [7:0] s_c, b_c;
  logic [bbsg_pkg::DIV_NUM_W-1:0] div_num, quot;
  logic [bbsg_pkg::DIV_DEN_W-1:0] div_den;
  logic div_busy, div_done;

  function automatic logic [7:0] chan8(input logic [31:0] p, input logic [1:0] ci);
    logic [7:0] v;
    case (ci)
      2'd0:    v = p[7:0];
      2'd1:    v = p[15:8];
      2'd2:    v = p[23:16];
      default: v = p[31:24];
    endcase
    return v;
  endfunction

  assign w = (fw == '0) ? DW'(1) : (fw > DW'(bbsg_pkg::MAX_WIDTH)) ?
             DW'(bbsg_pkg::MAX_WIDTH) : fw;
  assign h = (fh == '0) ? DW'(1) : (fh > DW'(bbsg_pkg::MAX_HEIGHT)) ?
             DW'(bbsg_pkg::MAX_HEIGHT) : fh;
  assign r = (rad > bbsg_pkg::RAD_W'(bbsg_pkg::MAX_RADIUS)) ?
             bbsg_pkg::RAD_W'(bbsg_pkg::MAX_RADIUS) : rad;
  assign k = (str > bbsg_pkg::STR_W'(bbsg_pkg::FULL_STRENGTH)) ?
             bbsg_pkg::STR_W'(bbsg_pkg::FULL_STRENGTH) : str;
  assign size = SW'(w) * SW'(h);

  assign rd_idx   = ({1'b0, read_pos} < size) ? read_pos : '0;
  assign idx_last = (SW'(rd_idx) + SW'(1)) == size;

  assign coord = pass_v ? y : x;
  assign dim9  = pass_v ? 9'(h) : 9'(w);
  assign lo9   = (9'(coord) >= 9'(r)) ? 9'(coord) - 9'(r) : '0;
  assign hi9   = ((9'(coord) + 9'(r)) < dim9) ? 9'(coord) + 9'(r) : dim9 - 9'd1;
  assign lo    = lo9[XW-1:0];
  assign hi    = hi9[XW-1:0];
  assign lo_w  = 15'(lo) * 15'(w);

  assign src_ra  = !cmd.run_mode ? rd_idx : (pass_v ? pos : win_addr);
  assign acc_src = pass_v ? {8'd0, row_rd} : src_rd;

  assign s_c = chan8(src_rd, c);
  assign b_c = b[c];

  // divide by 255 * 256: drop the low byte, then exact divide by 255
  assign blend_sum = keep + m3;
  assign blend_t   = blend_sum[23:8];
  assign blend_q   = blend_t + 16'(blend_t[15:8]) + 16'd1;
  assign glow_q    = blend_q[15:8];

  assign div_num = bbsg_pkg::DIV_NUM_W'(sum[c]);
  assign div_den = bbsg_pkg::DIV_DEN_W'(win_cnt);

  bbsg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .quot  (quot),
    .busy  (div_busy),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (load_pos < size)) begin
      src_mem[load_pos[AW-1:0]] <= {item.alpha_in, item.blue_in, item.green_in,
                                    item.red_in};
    end
    if (cmd.row_wr) begin
      row_mem[pos] <= {b[2], b[1], b[0]};
    end
    if (cmd.glow_wr) begin
      glow_mem[pos] <= {g[2], g[1], g[0]};
    end else if (cmd.copy_wr) begin
      glow_mem[pos] <= src_rd[23:0];
    end
    src_rd  <= src_mem[src_ra];
    row_rd  <= row_mem[win_addr];
    glow_rd <= glow_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fw           <= DW'(128);
      fh           <= DW'(128);
      rad          <= bbsg_pkg::RAD_W'(15);
      str          <= bbsg_pkg::STR_W'(128);
      load_pos     <= '0;
      read_pos     <= '0;
      result_valid <= 1'b0;
      pass_v       <= 1'b0;
      acc_d        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bbsg_pkg::REG_WIDTH:    fw  <= cfg_data[DW-1:0];
          bbsg_pkg::REG_HEIGHT:   fh  <= cfg_data[DW-1:0];
          bbsg_pkg::REG_RADIUS:   rad <= cfg_data[bbsg_pkg::RAD_W-1:0];
          bbsg_pkg::REG_STRENGTH: str <= cfg_data[bbsg_pkg::STR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load_wr) begin
        load_pos <= (load_pos < size) ? load_pos + SW'(1) : size;
      end
      if (cmd.rd_accept) begin
        read_pos <= idx_last ? '0 : rd_idx + AW'(1);
      end
      if (cmd.run_done) begin
        load_pos <= '0;
        read_pos <= '0;
      end
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      acc_d <= cmd.win_step;
      if (cmd.run_init) begin
        pass_v <= (r == '0);
      end else if (cmd.pix_next && stat.last_x && stat.last_y) begin
        pass_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_accept) begin
      rd_last <= idx_last;
    end
    if (cmd.out_load) begin
      result <= {glow_rd[7:0], glow_rd[15:8], glow_rd[23:16], src_rd[31:24], rd_last};
    end
    if (cmd.run_init) begin
      x        <= '0;
      y        <= '0;
      pos      <= '0;
      row_base <= '0;
    end else if (cmd.pix_next) begin
      pos <= pos + AW'(1);
      x   <= x + XW'(1);
      if (stat.last_x) begin
        x        <= '0;
        y        <= y + XW'(1);
        row_base <= row_base + AW'(w);
        if (stat.last_y) begin
          y        <= '0;
          pos      <= '0;
          row_base <= '0;
        end
      end
    end
    if (cmd.pix_start) begin
      win_n    <= lo;
      win_hi   <= hi;
      win_cnt  <= bbsg_pkg::CNT_W'(hi - lo) + bbsg_pkg::CNT_W'(1);
      win_addr <= pass_v ? AW'(lo_w + 15'(x)) : row_base + AW'(lo);
      c        <= '0;
      for (int i = 0; i < 3; i++) begin
        sum[i] <= '0;
      end
    end else begin
      if (cmd.win_step) begin
        win_n    <= win_n + XW'(1);
        win_addr <= pass_v ? win_addr + AW'(w) : win_addr + AW'(1);
      end
      if (acc_d) begin
        for (int i = 0; i < 3; i++) begin
          sum[i] <= sum[i] + bbsg_pkg::SUM_W'(chan8(acc_src, 2'(i)));
        end
      end
      if (cmd.chan_next) begin
        c <= c + 2'd1;
      end
    end
    if (cmd.take_blur) begin
      b[c] <= quot[7:0];
    end
    if (cmd.take_glow) begin
      g[c] <= glow_q;
    end
    if (cmd.blend1) begin
      m1 <= 17'(bbsg_pkg::STR_W'(bbsg_pkg::FULL_STRENGTH) - k) * 17'(s_c);
      m2 <= 16'(8'd255 - s_c) * 16'(8'd255 - b_c);
    end
    if (cmd.blend2) begin
      keep <= {m1, 8'd0} - 25'(m1);
      m3   <= 25'(k) * 25'(16'(bbsg_pkg::SCREEN_TOP) - m2);
    end
  end

  assign stat.r_zero    = (r == '0);
  assign stat.pass_v    = pass_v;
  assign stat.win_last  = (win_n == win_hi);
  assign stat.div_done  = div_done;
  assign stat.div_busy  = div_busy;
  assign stat.chan_last = (c == 2'd2);
  assign stat.last_x    = ({1'b0, x} == (w - DW'(1)));
  assign stat.last_y    = ({1'b0, y} == (h - DW'(1)));
  assign stat.out_valid = result_valid;

endmodule

### hdl/bbsg_ctrl.sv
// ---------------------------------------------------------------------------
// bbsg_ctrl
// Controller: command decode and the per-pixel filter sequence.
// ---------------------------------------------------------------------------
module bbsg_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic [1:0]           item_cmd,
  output logic                 item_stall,
  input  bbsg_pkg::ctrl_stat_t stat,
  output bbsg_pkg::ctrl_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_WIN   = 4'd3;
  localparam logic [3:0] S_DRAIN = 4'd4;
  localparam logic [3:0] S_BDIV  = 4'd5;
  localparam logic [3:0] S_BWAIT = 4'd6;
  localparam logic [3:0] S_BL1   = 4'd7;
  localparam logic [3:0] S_BL2   = 4'd8;
  localparam logic [3:0] S_GDIV  = 4'd9;
  localparam logic [3:0] S_WRITE = 4'd11;
  localparam logic [3:0] S_CRD   = 4'd12;
  localparam logic [3:0] S_CWR   = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state, state_next;
  logic       accept;

  assign item_stall = (state != S_IDLE) ||
                      (stat.out_valid && (item_cmd == bbsg_pkg::CMD_READ));
  assign accept = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    cmd.run_mode = (state != S_IDLE) && (state != S_RD);
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          case (item_cmd)
            bbsg_pkg::CMD_LOAD: cmd.load_wr = 1'b1;
            bbsg_pkg::CMD_RUN: begin
              cmd.run_init = 1'b1;
              state_next   = stat.r_zero ? S_CRD : S_START;
            end
            bbsg_pkg::CMD_READ: begin
              cmd.rd_accept = 1'b1;
              state_next    = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.out_load = 1'b1;
        state_next   = S_IDLE;
      end
      S_START: begin
        cmd.pix_start = 1'b1;
        state_next    = S_WIN;
      end
      S_WIN: begin
        cmd.win_step = 1'b1;
        if (stat.win_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_BDIV;
      S_BDIV: begin
        cmd.div_go = 1'b1;
        state_next = S_BWAIT;
      end
      S_BWAIT: begin
        if (stat.div_done) begin
          cmd.take_blur = 1'b1;
          if (stat.pass_v) begin
            state_next = S_BL1;
          end else if (stat.chan_last) begin
            state_next = S_WRITE;
          end else begin
            cmd.chan_next = 1'b1;
            state_next    = S_BDIV;
          end
        end
      end
      S_BL1: begin
        cmd.blend1 = 1'b1;
        state_next = S_BL2;
      end
      S_BL2: begin
        cmd.blend2 = 1'b1;
        state_next = S_GDIV;
      end
      S_GDIV: begin
        cmd.take_glow = 1'b1;
        if (stat.chan_last) begin
          state_next = S_WRITE;
        end else begin
          cmd.chan_next = 1'b1;
          state_next    = S_BDIV;
        end
      end
      S_WRITE: begin
        cmd.glow_wr  = stat.pass_v;
        cmd.row_wr   = !stat.pass_v;
        cmd.pix_next = 1'b1;
        state_next   = (stat.last_x && stat.last_y && stat.pass_v) ? S_DONE : S_START;
      end
      S_CRD: state_next = S_CWR;
      S_CWR: begin
        cmd.copy_wr  = 1'b1;
        cmd.pix_next = 1'b1;
        state_next   = (stat.last_x && stat.last_y) ? S_DONE : S_CRD;
      end
      S_DONE: begin
        cmd.run_done = 1'b1;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for box_blur_screen_glow: loads frames, runs the glow
// filter and reads results back, checking every pixel against a local model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [1:0]                   cfg_index;
  logic [bbsg_pkg::CFG_W-1:0]   cfg_data;
  logic                         item_valid;
  logic                         item_stall;
  bbsg_pkg::in_item_t           item;
  logic                         result_valid;
  logic                         result_stall;
  bbsg_pkg::out_item_t          result;

  box_blur_screen_glow i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // glow model state
  logic [31:0] src_mem  [bbsg_pkg::DEPTH];
  logic [23:0] row_mem  [bbsg_pkg::DEPTH];
  logic [23:0] glow_mem [bbsg_pkg::DEPTH];
  int unsigned load_pos;
  int unsigned read_pos;
  int unsigned width_reg;
  int unsigned height_reg;
  int unsigned radius_reg;
  int unsigned strength_reg;

  bbsg_pkg::out_item_t expected_pixels [$];
  int          errors;
  int          sent_items;
  bit          tx_quiet;
  bit          rx_quiet;
  int          stall_left;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic int unsigned sat_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned screen_mix(int unsigned s, int unsigned b, int unsigned k);
    int unsigned keep;
    int unsigned scr;
    keep = (bbsg_pkg::FULL_STRENGTH - k) * s * 255;
    scr  = bbsg_pkg::SCREEN_TOP - (255 - s) * (255 - b);
    return (keep + k * scr) / bbsg_pkg::BLEND_DIV;
  endfunction

  task automatic compute_glow(int unsigned w, int unsigned h);
    int unsigned r;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    int unsigned sum;
    logic [23:0] val;
    logic [31:0] sp;
    r = (radius_reg > bbsg_pkg::MAX_RADIUS) ? bbsg_pkg::MAX_RADIUS : radius_reg;
    k = (strength_reg > bbsg_pkg::FULL_STRENGTH) ? bbsg_pkg::FULL_STRENGTH : strength_reg;
    if (r == 0) begin
      for (int i = 0; i < w * h; i++) glow_mem[i] = src_mem[i][23:0];
      return;
    end
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        lo = (x >= r) ? x - r : 0;
        hi = (x + r < w) ? x + r : w - 1;
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int n = lo; n <= hi; n++) sum += src_mem[y * w + n][8 * c +: 8];
          val[8 * c +: 8] = sum / (hi - lo + 1);
        end
        row_mem[y * w + x] = val;
      end
    end
    for (int y = 0; y < h; y++) begin
      lo = (y >= r) ? y - r : 0;
      hi = (y + r < h) ? y + r : h - 1;
      for (int x = 0; x < w; x++) begin
        sp = src_mem[y * w + x];
        for (int c = 0; c < 3; c++) begin
          sum = 0;
          for (int n = lo; n <= hi; n++) sum += row_mem[n * w + x][8 * c +: 8];
          val[8 * c +: 8] = screen_mix(sp[8 * c +: 8], sum / (hi - lo + 1), k);
        end
        glow_mem[y * w + x] = val;
      end
    end
  endtask

  task automatic predict_glow(bbsg_pkg::in_item_t it);
    int unsigned w;
    int unsigned h;
    int unsigned size;
    int unsigned idx;
    bbsg_pkg::out_item_t px;
    w = sat_dim(width_reg, bbsg_pkg::MAX_WIDTH);
    h = sat_dim(height_reg, bbsg_pkg::MAX_HEIGHT);
    size = w * h;
    case (it.cmd)
      bbsg_pkg::CMD_LOAD: begin
        if (load_pos < size) begin
          src_mem[load_pos] = {it.alpha_in, it.blue_in, it.green_in, it.red_in};
          load_pos++;
        end else begin
          load_pos = size;
        end
      end
      bbsg_pkg::CMD_RUN: begin
        compute_glow(w, h);
        load_pos = 0;
        read_pos = 0;
      end
      bbsg_pkg::CMD_READ: begin
        idx = (read_pos < size) ? read_pos : 0;
        px.red_out    = glow_mem[idx][7:0];
        px.green_out  = glow_mem[idx][15:8];
        px.blue_out   = glow_mem[idx][23:16];
        px.alpha_out  = src_mem[idx][31:24];
        px.last_pixel = (idx + 1 == size);
        read_pos = (idx + 1 == size) ? 0 : idx + 1;
        expected_pixels.push_back(px);
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (tx_quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(logic [1:0] cmd, logic [31:0] pix);
    int gap;
    bbsg_pkg::in_item_t it;
    gap = pick_gap();
    it.cmd      = cmd;
    it.red_in   = pix[7:0];
    it.green_in = pix[15:8];
    it.blue_in  = pix[23:16];
    it.alpha_in = pix[31:24];
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    predict_glow(it);
    if (cmd != CMD_NONE) sent_items++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value[bbsg_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (index)
      bbsg_pkg::REG_WIDTH:    width_reg    = value & 8'hFF;
      bbsg_pkg::REG_HEIGHT:   height_reg   = value & 8'hFF;
      bbsg_pkg::REG_RADIUS:   radius_reg   = value & 5'h1F;
      bbsg_pkg::REG_STRENGTH: strength_reg = value & 9'h1FF;
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, int unsigned r, int unsigned k);
    drain();
    write_reg(bbsg_pkg::REG_WIDTH, w);
    write_reg(bbsg_pkg::REG_HEIGHT, h);
    write_reg(bbsg_pkg::REG_RADIUS, r);
    write_reg(bbsg_pkg::REG_STRENGTH, k);
  endtask

  function automatic int unsigned frame_size();
    return sat_dim(width_reg, bbsg_pkg::MAX_WIDTH) * sat_dim(height_reg, bbsg_pkg::MAX_HEIGHT);
  endfunction

  task automatic load_frame();
    for (int i = 0; i < frame_size(); i++) send_item(bbsg_pkg::CMD_LOAD, $urandom());
  endtask

  task automatic read_pixels(int n);
    for (int i = 0; i < n; i++) send_item(bbsg_pkg::CMD_READ, $urandom());
  endtask

  task automatic test_directed();
    // one-pixel-wide frame, saturated radius and strength, extreme pixels
    set_frame(0, 2, 31, 511);
    send_item(bbsg_pkg::CMD_LOAD, 32'hFFFF_FFFF);
    send_item(bbsg_pkg::CMD_LOAD, 32'h0000_0000);
    send_item(bbsg_pkg::CMD_LOAD, 32'h1234_5678);
    send_item(CMD_NONE, 32'hFFFF_FFFF);
    send_item(bbsg_pkg::CMD_RUN, 32'h0);
    read_pixels(3);
    send_item(bbsg_pkg::CMD_LOAD, 32'hA5FF_00FF);
    read_pixels(2);
    // radius zero copy, zero strength, then shrink and restart the read
    set_frame(2, 2, 0, 0);
    send_item(bbsg_pkg::CMD_LOAD, 32'h00FF_00FF);
    send_item(bbsg_pkg::CMD_LOAD, 32'hFF00_FF00);
    send_item(bbsg_pkg::CMD_LOAD, 32'h0F0F_0F0F);
    send_item(bbsg_pkg::CMD_LOAD, 32'hF0F0_F0F0);
    send_item(bbsg_pkg::CMD_RUN, 32'h0);
    read_pixels(3);
    set_frame(2, 1, 0, 0);
    read_pixels(2);
    set_frame(2, 2, 1, 256);
    send_item(bbsg_pkg::CMD_RUN, 32'h0);
    read_pixels(4);
  endtask

  task automatic test_wide_row();
    set_frame(128, 1, 30, 256);
    load_frame();
    send_item(bbsg_pkg::CMD_RUN, 32'h0);
    read_pixels(128);
  endtask

  task automatic test_tall_column();
    set_frame(1, 128, $urandom_range(1, 30), $urandom_range(0, 256));
    load_frame();
    send_item(bbsg_pkg::CMD_RUN, 32'h0);
    read_pixels(129);
  endtask

  task automatic test_random_frames();
    int unsigned w;
    int unsigned h;
    int unsigned k;
    int n;
    while (sent_items < 1800) begin
      tx_quiet = ($urandom_range(0, 4) == 0);
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
      k = ($urandom_range(0, 5) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256);
      set_frame(w, h, $urandom_range(0, 31), k);
      for (int i = 0; i < frame_size(); i++) begin
        if ($urandom_range(0, 19) == 0) send_item(CMD_NONE, $urandom());
        send_item(bbsg_pkg::CMD_LOAD, $urandom());
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) send_item(bbsg_pkg::CMD_LOAD, $urandom());
      end
      send_item(bbsg_pkg::CMD_RUN, 32'h0);
      n = $urandom_range(1, 2 * frame_size());
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 49) == 0) drain();
        send_item(bbsg_pkg::CMD_READ, $urandom());
      end
      if ($urandom_range(0, 3) == 0) begin
        // reload a few pixels, read from the current read position, then rerun
        n = $urandom_range(1, frame_size());
        for (int i = 0; i < n; i++) send_item(bbsg_pkg::CMD_LOAD, $urandom());
        read_pixels($urandom_range(1, frame_size()));
        send_item(bbsg_pkg::CMD_RUN, 32'h0);
        read_pixels($urandom_range(1, frame_size()));
      end
    end
    tx_quiet = 1'b0;
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    int r;
    bbsg_pkg::out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result %h", result);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (result.red_out !== want.red_out) begin
          $error("red_out expected %0d got %0d", want.red_out, result.red_out);
          errors++;
        end
        if (result.green_out !== want.green_out) begin
          $error("green_out expected %0d got %0d", want.green_out, result.green_out);
          errors++;
        end
        if (result.blue_out !== want.blue_out) begin
          $error("blue_out expected %0d got %0d", want.blue_out, result.blue_out);
          errors++;
        end
        if (result.alpha_out !== want.alpha_out) begin
          $error("alpha_out expected %0d got %0d", want.alpha_out, result.alpha_out);
          errors++;
        end
        if (result.last_pixel !== want.last_pixel) begin
          $error("last_pixel expected %0d got %0d", want.last_pixel, result.last_pixel);
          errors++;
        end
      end
    end
    if ($urandom_range(0, 299) == 0) rx_quiet = ~rx_quiet;
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (rx_quiet) begin
      result_stall <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        result_stall <= 1'b0;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 3);
        result_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(10, 40);
        result_stall <= 1'b1;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = bbsg_pkg::REG_WIDTH;
    cfg_data     = '0;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    errors       = 0;
    sent_items   = 0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    stall_left   = 0;
    load_pos     = 0;
    read_pos     = 0;
    width_reg    = 128;
    height_reg   = 128;
    radius_reg   = 15;
    strength_reg = 128;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);
    test_directed();
    test_wide_row();
    test_tall_column();
    test_random_frames();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/bbsg_pkg.sv
hdl/bbsg_div.sv
hdl/bbsg_dp.sv
hdl/bbsg_ctrl.sv
hdl/box_blur_screen_glow.sv
sim/tb.sv
